[hw/rtl/isu_pkg.sv]
// Shared types and constants for the indexed sequence store.
// Holds opcodes, status codes, sizing constants and the cell command word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDXW     = $clog2(CAPACITY);
  localparam int unsigned CNTW     = $clog2(CAPACITY + 1);
  localparam int unsigned DATAW    = 32;
  localparam int unsigned POSW     = 16;
  localparam int unsigned OPW      = 3;
  localparam int unsigned STW      = 2;
  localparam int unsigned COUNTW   = 7;
  // Read results are gathered in groups of this many cells before the final OR.
  localparam int unsigned GRP      = 8;
  localparam int unsigned NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [OPW-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_e;

  typedef enum logic [STW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [IDXW-1:0]  pos;
    logic [DATAW-1:0] value;
  } isu_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/indexed_sequence_store_unit.sv]
// Top level of the indexed sequence store: command decode, the row of cells and
// a registered OR tree that gathers read data. Depends on isu_pkg and isu_cell.
// The done_o strobe is registered through s1_valid_q and s2_valid_q after the command is accepted.
// Throughput: one command per cycle; busy is never raised, as every command
// updates the cell row in its accept cycle and the read path is a 3-stage pipeline.
// Reset clears the element count and the result strobes; element words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [isu_pkg::OPW-1:0]     opcode_i,
  input  wire logic [isu_pkg::POSW-1:0]    position_i,
  input  wire logic [isu_pkg::DATAW-1:0]   value_i,
  output logic                             done_o,
  output logic      [isu_pkg::STW-1:0]     status_o,
  output logic      [isu_pkg::DATAW-1:0]   read_value_o,
  output logic      [isu_pkg::COUNTW-1:0]  count_o
);
  import isu_pkg::*;

  logic             accept;
  logic [CNTW-1:0]  count_q, count_d;
  logic [POSW-1:0]  cnt_ext;
  logic             full;
  status_e          status_d;
  isu_cmd_t         cmd;

  logic [DATAW-1:0] cell_data [CAPACITY];
  logic [DATAW-1:0] cell_rd   [CAPACITY];

  logic             s1_valid_q, s2_valid_q;
  status_e          s1_status_q, s2_status_q;
  logic [CNTW-1:0]  s1_count_q, s2_count_q;
  logic [DATAW-1:0] grp_d [NGRP];
  logic [DATAW-1:0] grp_q [NGRP];
  logic [DATAW-1:0] rd_all;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_ext = POSW'(count_q);
  assign full    = (count_q == CNTW'(CAPACITY));

  always_comb begin
    cmd       = '0;
    cmd.value = value_i;
    cmd.pos   = position_i[IDXW-1:0];
    status_d  = ST_DONE;
    count_d   = count_q;
    if (accept) begin
      case (opcode_i)
        OP_READ: begin
          if (position_i < cnt_ext) begin
            cmd.rd = 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_INS_HEAD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cmd.pos = '0;
            count_d = count_q + 1'b1;
          end
        end
        OP_INS_TAIL: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cmd.pos = count_q[IDXW-1:0];
            count_d = count_q + 1'b1;
          end
        end
        OP_INS_AT: begin
          // The range check takes priority over the full check.
          if (position_i > cnt_ext) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_DELETE: begin
          if (position_i < cnt_ext) begin
            cmd.del = 1'b1;
            count_d = count_q - 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATAW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    isu_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDXW'(i)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // First level of the read tree: at most one cell offers a non-zero word.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= status_d;
    s1_count_q  <= count_d;
    s2_status_q <= s1_status_q;
    s2_count_q  <= s1_count_q;
    grp_q       <= grp_d;
    status_o     <= s2_status_q;
    read_value_o <= rd_all;
    count_o      <= COUNTW'(s2_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      count_q    <= count_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      done_o     <= s2_valid_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted command produced no result after three cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("element count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ins, cmd.del, cmd.rd}))
    else $error("more than one cell operation issued at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> count_q == $past(count_q))
    else $error("element count changed without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_DONE)) |-> (read_value_o == '0))
    else $error("failed command returned a non-zero read word");

endmodule

`default_nettype wire

[hw/rtl/isu_cell.sv]
// One storage cell of the sequence store row.
// Holds a single element, shifts to or from its neighbours and offers its word on a read.
// Depends on isu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isu_cell (
  input  wire logic                    clk_i,
  input  wire logic [isu_pkg::IDXW-1:0]  idx_i,
  input  wire isu_pkg::isu_cmd_t       cmd_i,
  input  wire logic [isu_pkg::DATAW-1:0] left_i,
  input  wire logic [isu_pkg::DATAW-1:0] right_i,
  output logic      [isu_pkg::DATAW-1:0] data_o,
  output logic      [isu_pkg::DATAW-1:0] rd_o
);
  import isu_pkg::*;

  logic [DATAW-1:0] data_q, data_d;
  logic [DATAW-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.pos) begin
        data_d = left_i;
      end else if (idx_i == cmd_i.pos) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      // Everything from the deleted slot onwards moves one place towards the head.
      if (idx_i >= cmd_i.pos) begin
        data_d = right_i;
      end
    end
  end

  assign rd_d = (cmd_i.rd && (idx_i == cmd_i.pos)) ? data_q : '0;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for indexed_sequence_store_unit.
// Keeps a shadow copy of the stored sequence, predicts every result and checks
// it against the strobed outputs. Depends on isu_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import isu_pkg::*;

  // Opcodes that the unit must ignore.
  localparam logic [OPW-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE_C = 3'd7;

  localparam int unsigned DUT_LATENCY  = 3;
  localparam int unsigned STALL_LIMIT  = 200;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned CALM_TAIL    = 150;

  typedef enum {PH_MIX, PH_FILL, PH_DRAIN} phase_e;

  typedef struct packed {
    logic [STW-1:0]    status;
    logic [DATAW-1:0]  read_value;
    logic [COUNTW-1:0] count;
  } store_result_t;

  class store_shadow;
    logic [DATAW-1:0] slots [CAPACITY];
    int unsigned      shadow_len;
    store_result_t    expected_results [$];
    int unsigned      errors;
    int unsigned      commands;
    int unsigned      checked;
    int unsigned      peak_len;
    int unsigned      status_seen [3];

    function new();
      shadow_len = 0;
      errors     = 0;
      commands   = 0;
      checked    = 0;
      peak_len   = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Opens a gap at slot at and stores v there; room and index are checked by the caller.
    function void place(int unsigned at, logic [DATAW-1:0] v);
      for (int unsigned i = shadow_len; i > at; i--) slots[i] = slots[i - 1];
      slots[at] = v;
      shadow_len++;
      if (shadow_len > peak_len) peak_len = shadow_len;
    endfunction

    function void note_command(logic [OPW-1:0] op, logic [POSW-1:0] pos,
                               logic [DATAW-1:0] val);
      store_result_t r;
      bit            full;
      r.status     = ST_DONE;
      r.read_value = '0;
      full         = shadow_len >= CAPACITY;
      commands++;
      case (op)
        OP_READ: begin
          if (pos < shadow_len) r.read_value = slots[pos];
          else r.status = ST_RANGE;
        end
        OP_INS_HEAD: begin
          if (full) r.status = ST_FULL;
          else place(0, val);
        end
        OP_INS_TAIL: begin
          if (full) r.status = ST_FULL;
          else place(shadow_len, val);
        end
        OP_INS_AT: begin
          // The range check takes precedence over the full check.
          if (pos > shadow_len) r.status = ST_RANGE;
          else if (full) r.status = ST_FULL;
          else place(pos, val);
        end
        OP_DELETE: begin
          if (pos < shadow_len) begin
            for (int unsigned i = pos; i + 1 < shadow_len; i++) slots[i] = slots[i + 1];
            shadow_len--;
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      r.count = COUNTW'(shadow_len);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STW-1:0] status, logic [DATAW-1:0] read_value,
                               logic [COUNTW-1:0] count);
      store_result_t e;
      if (expected_results.size() == 0) begin
        $error("result word with no command outstanding: status %0d value %h count %0d",
               status, read_value, count);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (e.status < 3) status_seen[e.status]++;
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (read_value !== e.read_value) begin
        $error("read_value: expected %h, got %h", e.read_value, read_value);
        errors++;
      end
      if (count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  logic [OPW-1:0]    opcode_i   = '0;
  logic [POSW-1:0]   position_i = '0;
  logic [DATAW-1:0]  value_i    = '0;
  logic              done_o;
  logic [STW-1:0]    status_o;
  logic [DATAW-1:0]  read_value_o;
  logic [COUNTW-1:0] count_o;

  store_shadow tracker = new();
  int unsigned stall_cycles = 0;

  indexed_sequence_store_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(status_o, read_value_o, count_o);
      if (start && !busy) tracker.note_command(opcode_i, position_i, value_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $error("no word moved for %0d cycles", stall_cycles);
      $display("FAIL indexed_sequence_store_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_command(input logic [OPW-1:0] op, input logic [POSW-1:0] pos,
                              input logic [DATAW-1:0] val);
    start      <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Fields are scrambled while start is low; the unit must ignore them.
  task automatic idle_for(input int unsigned n);
    start      <= 1'b0;
    opcode_i   <= OPW'($urandom());
    position_i <= POSW'($urandom());
    value_i    <= $urandom();
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_settled();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATAW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POSW-1:0] pick_position(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return POSW'($urandom_range(0, len));
    if (r < 8) return POSW'(len + 1);
    return POSW'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [OPW-1:0] pick_opcode(phase_e ph);
    int unsigned r;
    int unsigned ins_pct;
    int unsigned rd_pct;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin ins_pct = 75; rd_pct = 15; end
      PH_DRAIN: begin ins_pct = 11; rd_pct = 15; end
      default:  begin ins_pct = 35; rd_pct = 30; end
    endcase
    if (r < 4) return OP_SPARE_A + OPW'($urandom_range(0, 2));
    if (r < 4 + ins_pct) begin
      case ($urandom_range(0, 2))
        0: return OP_INS_HEAD;
        1: return OP_INS_TAIL;
        default: return OP_INS_AT;
      endcase
    end
    if (r < 4 + ins_pct + rd_pct) return OP_READ;
    return OP_DELETE;
  endfunction

  // A fill phase runs on into a full store, a drain phase on past empty.
  task automatic run_phase(input phase_e ph, input bit gappy, inout int unsigned items);
    int unsigned     n;
    int unsigned     extra;
    int unsigned     target;
    logic [OPW-1:0]  op;
    n      = 0;
    extra  = 0;
    target = $urandom_range(40, 80);
    while (1) begin
      if (items >= RANDOM_ITEMS) break;
      if (ph == PH_FILL && (n >= 300 || (tracker.shadow_len == CAPACITY && extra >= 12))) break;
      if (ph == PH_DRAIN && (n >= 300 || (tracker.shadow_len == 0 && extra >= 8))) break;
      if (ph == PH_MIX && n >= target) break;
      if ((ph == PH_FILL && tracker.shadow_len == CAPACITY) ||
          (ph == PH_DRAIN && tracker.shadow_len == 0)) extra++;
      op = pick_opcode(ph);
      send_command(op, pick_position(tracker.shadow_len), pick_value());
      n++;
      items++;
      if (gappy && (items + CALM_TAIL < RANDOM_ITEMS) && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 14));
    end
  endtask

  initial begin
    int unsigned items;
    int unsigned phase_no;
    phase_e      ph;
    bit          gappy;
    items    = 0;
    phase_no = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, both ends, insert at the end index, bad indices,
    // value extremes, ignored opcodes and deletes at both ends.
    send_command(OP_READ, 0, 32'h1234_5678);
    send_command(OP_DELETE, 0, '0);
    send_command(OP_INS_AT, 1, 32'h0BAD_0BAD);
    send_command(OP_INS_AT, 0, 32'h0000_0001);
    send_command(OP_INS_HEAD, 16'hFFFF, 32'h8000_0000);
    send_command(OP_INS_TAIL, 0, 32'h7FFF_FFFF);
    idle_for(3);
    send_command(OP_INS_HEAD, 0, 32'hFFFF_FFFF);
    send_command(OP_INS_AT, 1, 32'h0000_0000);
    send_command(OP_INS_AT, 5, 32'h5555_5555);
    send_command(OP_READ, 0, '1);
    send_command(OP_READ, 5, '0);
    send_command(OP_READ, 6, '0);
    send_command(OP_READ, 16'hFFFF, '0);
    send_command(OP_DELETE, 16'hFFFF, '0);
    send_command(OP_INS_AT, 16'hFFFF, 32'hAAAA_AAAA);
    send_command(OP_SPARE_A, 16'hFFFF, '1);
    send_command(OP_SPARE_B, 0, 32'h8000_0000);
    send_command(OP_SPARE_C, 16'h5A5A, 32'h7FFF_FFFF);
    send_command(OP_DELETE, 0, '0);
    send_command(OP_DELETE, 4, '0);
    send_command(OP_INS_AT, 2, 32'hAAAA_AAAA);
    send_command(OP_READ, 2, '0);
    send_command(OP_READ, 4, '0);
    wait_settled();

    while (items < RANDOM_ITEMS) begin
      case (phase_no % 4)
        0: ph = PH_FILL;
        2: ph = PH_DRAIN;
        default: ph = PH_MIX;
      endcase
      gappy = (items + CALM_TAIL < RANDOM_ITEMS) && ($urandom_range(0, 2) != 0);
      run_phase(ph, gappy, items);
      if (phase_no == 0 || $urandom_range(0, 1) == 0) wait_settled();
      phase_no++;
    end

    wait_settled();
    repeat (DUT_LATENCY + 4) @(posedge clk_i);
    $display("Checked %0d results over %0d commands: %0d done, %0d out of range, %0d full.",
             tracker.checked, tracker.commands, tracker.status_seen[ST_DONE],
             tracker.status_seen[ST_RANGE], tracker.status_seen[ST_FULL]);
    $display("Occupancy peaked at %0d of %0d slots across %0d random phases.",
             tracker.peak_len, CAPACITY, phase_no);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS indexed_sequence_store_unit");
    end else begin
      $display("FAIL indexed_sequence_store_unit");
    end
    $finish;
  end

endmodule
